/* sv/oahm_pkg.sv */
// Shared constants for the open-addressing hash map.
`default_nettype none
package oahm_pkg;
	// Slot count; must be a power of two, since the home slot is taken from the low key bits.
	localparam int CAPACITY = 256;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CMD_W = 2;
	localparam int LIMIT_W = 8;
	localparam int OCC_W = 9;

	localparam logic [CMD_W-1:0] CMD_GET = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd192;
endpackage
`default_nettype wire

/* sv/open_address_hash_map.sv */
// Top level of the open-addressing hash map with linear probing and tombstones.
//
// After reset the block clears its slot table, one slot per clock cycle, and holds busy
// high until every slot is clear, before the first word can be taken. A word is taken
// when start is high and busy is low. The block then probes one slot per clock cycle from
// the key's home slot (the low key bits) until it meets the key, an empty slot, or has
// visited every slot. The status, key and value memories each have a single read port,
// read one slot per cycle. The result appears for exactly one cycle on hit, value_out
// and full_res, marked by done, in the cycle after the last probe; it cannot be held
// off, and a new word may be taken in that same cycle. An unused command gives an
// all-zero result in the cycle after it is taken. The occupancy limit limit_q is written
// through cfg_we and cfg_data; the user writes it only while the block is idle, which
// the block itself does not enforce.
`default_nettype none
module open_address_hash_map (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [oahm_pkg::CMD_W-1:0]    command,
	input  wire logic [oahm_pkg::KEY_W-1:0]    key,
	input  wire logic [oahm_pkg::VAL_W-1:0]    value_in,
	output logic                               done,
	output logic                               hit,
	output logic [oahm_pkg::VAL_W-1:0]         value_out,
	output logic                               full_res,
	input  wire logic                          cfg_we,
	input  wire logic [oahm_pkg::LIMIT_W-1:0]  cfg_data
);
	import oahm_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_PROBE = 2'd2;

	localparam logic [1:0] SLOT_EMPTY = 2'd0;
	localparam logic [1:0] SLOT_LIVE  = 2'd1;
	localparam logic [1:0] SLOT_TOMB  = 2'd2;

	logic [1:0]          state_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    val_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    cnt_q;
	logic                tseen_q;
	logic [IDX_W-1:0]    tomb_at_q;
	logic [OCC_W-1:0]    occ_q;
	logic [LIMIT_W-1:0]  limit_q;

	logic [1:0]       st_mem  [CAPACITY];
	logic [KEY_W-1:0] key_mem [CAPACITY];
	logic [VAL_W-1:0] val_mem [CAPACITY];
	logic [1:0]       rd_st_q;
	logic [KEY_W-1:0] rd_key_q;
	logic [VAL_W-1:0] rd_val_q;

	logic             done_q;
	logic             hit_q;
	logic [VAL_W-1:0] vout_q;
	logic             full_q;

	logic             accept;
	logic             clearing;
	logic [IDX_W-1:0] rd_addr;
	logic             cur_live;
	logic             cur_tomb;
	logic             cur_empty;
	logic             cur_match;
	logic             last;
	logic             finish;
	logic             tomb_now;
	logic [IDX_W-1:0] tomb_at_now;
	logic             key_we;
	logic             val_we;
	logic [IDX_W-1:0] wr_addr;
	logic             set_live;
	logic             set_tomb;
	logic             st_we;
	logic [IDX_W-1:0] st_waddr;
	logic [1:0]       st_wdata;
	logic             occ_inc;
	logic             res_hit;
	logic [VAL_W-1:0] res_val;
	logic             res_full;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign clearing = (state_q == ST_CLEAR);

	// The read address runs one slot ahead, so the registered data matches idx_q.
	assign rd_addr = (state_q == ST_IDLE) ? key[IDX_W-1:0] : idx_q + IDX_W'(1);

	assign cur_live    = (rd_st_q == SLOT_LIVE);
	assign cur_tomb    = (rd_st_q == SLOT_TOMB);
	assign cur_empty   = !cur_live && !cur_tomb;
	assign cur_match   = cur_live && (rd_key_q == key_q);
	assign last        = (cnt_q == IDX_W'(CAPACITY - 1));
	assign finish      = (state_q == ST_PROBE) && (cur_empty || cur_match || last);
	assign tomb_now    = tseen_q || cur_tomb;
	assign tomb_at_now = tseen_q ? tomb_at_q : idx_q;

	always_comb begin
		key_we   = 1'b0;
		val_we   = 1'b0;
		wr_addr  = idx_q;
		set_live = 1'b0;
		set_tomb = 1'b0;
		occ_inc  = 1'b0;
		res_hit  = 1'b0;
		res_val  = '0;
		res_full = 1'b0;
		if (finish) begin
			case (cmd_q)
				CMD_GET: begin
					if (cur_match) begin
						res_hit = 1'b1;
						res_val = rd_val_q;
					end
				end
				CMD_SET: begin
					if (cur_match) begin
						val_we = 1'b1;
					end else if (tomb_now) begin
						key_we   = 1'b1;
						val_we   = 1'b1;
						wr_addr  = tomb_at_now;
						set_live = 1'b1;
						res_hit  = 1'b1;
					end else if (cur_empty && (occ_q < {1'b0, limit_q})) begin
						key_we   = 1'b1;
						val_we   = 1'b1;
						set_live = 1'b1;
						occ_inc  = 1'b1;
						res_hit  = 1'b1;
					end else begin
						res_full = 1'b1;
					end
				end
				CMD_DEL: begin
					if (cur_match) begin
						set_tomb = 1'b1;
						res_hit  = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// While clearing, cnt_q walks the status memory and marks every slot empty.
	assign st_we    = clearing || set_live || set_tomb;
	assign st_waddr = clearing ? cnt_q : wr_addr;
	assign st_wdata = clearing ? SLOT_EMPTY : (set_tomb ? SLOT_TOMB : SLOT_LIVE);

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_waddr] <= st_wdata;
		end
		rd_st_q <= st_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wr_addr] <= key_q;
		end
		rd_key_q <= key_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[wr_addr] <= val_q;
		end
		rd_val_q <= val_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			key_q <= key;
			val_q <= value_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			idx_q     <= '0;
			cnt_q     <= '0;
			tseen_q   <= 1'b0;
			tomb_at_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (command != CMD_NOP)) begin
						state_q <= ST_PROBE;
						idx_q   <= key[IDX_W-1:0];
						cnt_q   <= '0;
						tseen_q <= 1'b0;
					end
				end
				ST_PROBE: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
						cnt_q <= cnt_q + IDX_W'(1);
						if (cur_tomb && !tseen_q) begin
							tseen_q   <= 1'b1;
							tomb_at_q <= idx_q;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (occ_inc) begin
			occ_q <= occ_q + OCC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			hit_q  <= 1'b0;
			vout_q <= '0;
			full_q <= 1'b0;
		end else begin
			done_q <= finish || (accept && (command == CMD_NOP));
			hit_q  <= res_hit;
			vout_q <= res_val;
			full_q <= res_full;
		end
	end

	assign done      = done_q;
	assign hit       = hit_q;
	assign value_out = vout_q;
	assign full_res  = full_q;
endmodule
`default_nettype wire

/* sv/oahm_checker.sv */
// Port-level checks for the hash map, bound to the top level.
`default_nettype none
module oahm_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic [oahm_pkg::CMD_W-1:0]    command,
	input wire logic                          done,
	input wire logic                          hit,
	input wire logic [oahm_pkg::VAL_W-1:0]    value_out,
	input wire logic                          full_res
);
	import oahm_pkg::*;

	// A result is only ever shown once the probe has finished.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still probing");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && full_res) |-> (!hit && (value_out == '0)))
		else $error("refused set reports a hit or a value");

	a_value_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (value_out != '0)) |-> hit)
		else $error("value returned without a hit");

	a_nop: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == CMD_NOP)) |=>
			(done && !hit && !full_res && (value_out == '0) && !busy))
		else $error("unused command did not give an empty result");

	a_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command != CMD_NOP)) |=> (busy && !done))
		else $error("operation did not start probing");
endmodule

bind open_address_hash_map oahm_checker u_oahm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.command   (command),
	.done      (done),
	.hit       (hit),
	.value_out (value_out),
	.full_res  (full_res)
);
`default_nettype wire
